FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/gdsw_pkg.sv
package gdsw_pkg;

    localparam int YearBits  = 14;
    localparam int MonthBits = 4;
    localparam int DayBits   = 5;
    localparam int SumBits   = 15;

    localparam logic [YearBits-1:0] YEAR_MAX = 14'd9999;

    // y / 100 == (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef enum logic [1:0] {
        REQ_NEXT = 2'd0,
        REQ_PREV = 2'd1,
        REQ_SAME = 2'd2
    } req_t;

    typedef struct packed {
        logic [YearBits-1:0]  year;
        logic [MonthBits-1:0] month;
        logic [DayBits-1:0]   day;
    } date_t;

    // stepped date plus the shifted year/month the weekday sum works on
    typedef struct packed {
        date_t                date;
        logic                 bad;
        logic [YearBits-1:0]  zy;
        logic [MonthBits-1:0] zm;
    } step_t;

    function automatic logic [DayBits-1:0] month_len(input logic leap,
                                                     input logic [MonthBits-1:0] m);
        logic [DayBits-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (13 * m + 8) / 5
    function automatic logic [5:0] month_term(input logic [MonthBits-1:0] m);
        logic [5:0] t;
        case (m)
            4'd0:    t = 6'd1;
            4'd1:    t = 6'd4;
            4'd2:    t = 6'd6;
            4'd3:    t = 6'd9;
            4'd4:    t = 6'd12;
            4'd5:    t = 6'd14;
            4'd6:    t = 6'd17;
            4'd7:    t = 6'd19;
            4'd8:    t = 6'd22;
            4'd9:    t = 6'd25;
            4'd10:   t = 6'd27;
            4'd11:   t = 6'd30;
            4'd12:   t = 6'd32;
            4'd13:   t = 6'd35;
            4'd14:   t = 6'd38;
            default: t = 6'd40;
        endcase
        return t;
    endfunction

endpackage

FILE: sv/gregorian_date_step_weekday.sv
// Gregorian date stepper with weekday.
// Input stream (s_axis): one request per transfer, tdata carries the
// operation (next day, previous day, same date) and the date.
// Output stream (m_axis): one result per request, in order: the result
// date and its weekday (0 Sunday .. 6 Saturday) in tdata, and tuser set
// when the result year lies outside 1..9999 (weekday is then 0).
// Each request passes four registers: the input register, the date step
// with leap-year test into the step register, the weekday sum with the
// divide-by-100 multiply into the sum register, then mod-7 reduction into
// the output register.
// Throughput is one request per cycle while the receiver keeps up; each
// stage holds one request and moves on as soon as the stage after it is free.
// When the receiver stalls, the output register holds its transfer and the
// stages fill up; s_axis_tready drops only when all four are occupied.
// Reset empties every stage; there is no other state.
`include "assert_macros.svh"

module gregorian_date_step_weekday (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // req_type[1:0], in_year[15:2], in_month[19:16],
                                       // in_day[24:20], zero [31:25]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_year[13:0], out_month[17:14], out_day[22:18],
                                       // weekday[25:23], zero [31:26]
    output logic        m_axis_tuser   // year_out_of_range
);

    logic            in_valid_reg, in_valid_next;
    logic [1:0]      in_req_reg, in_req_next;
    gdsw_pkg::date_t in_date_reg, in_date_next;

    logic            st_valid_reg, st_valid_next;
    gdsw_pkg::step_t st_reg, st_next;

    logic            sum_valid_reg, sum_valid_next;
    gdsw_pkg::date_t sum_date_reg, sum_date_next;
    logic            sum_bad_reg, sum_bad_next;
    logic [14:0]     sum_reg, sum_next;

    logic            out_valid_reg, out_valid_next;
    gdsw_pkg::date_t out_date_reg, out_date_next;
    logic [2:0]      out_wday_reg, out_wday_next;
    logic            out_bad_reg, out_bad_next;

    logic            out_ready;
    logic            sum_ready;
    logic            st_ready;
    gdsw_pkg::step_t step_res;
    logic [14:0]     dow_sum;
    logic [2:0]      dow_rem;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign sum_ready     = !sum_valid_reg || out_ready;
    assign st_ready      = !st_valid_reg || sum_ready;
    assign s_axis_tready = !in_valid_reg || st_ready;

    gdsw_step u_step (
        .req_type (in_req_reg),
        .in_date  (in_date_reg),
        .result   (step_res)
    );

    gdsw_dow_sum u_dow_sum (
        .zy  (st_reg.zy),
        .zm  (st_reg.zm),
        .day (st_reg.date.day),
        .sum (dow_sum)
    );

    gdsw_mod7 u_mod7 (
        .value (sum_reg),
        .rem   (dow_rem)
    );

    always_comb
    begin
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        in_req_next    = in_req_reg;
        in_date_next   = in_date_reg;
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_req_next        = s_axis_tdata[1:0];
            in_date_next.year  = s_axis_tdata[15:2];
            in_date_next.month = s_axis_tdata[19:16];
            in_date_next.day   = s_axis_tdata[24:20];
        end

        st_valid_next = st_ready ? in_valid_reg : st_valid_reg;
        st_next       = (st_ready && in_valid_reg) ? step_res : st_reg;

        sum_valid_next = sum_ready ? st_valid_reg : sum_valid_reg;
        sum_date_next  = sum_date_reg;
        sum_bad_next   = sum_bad_reg;
        sum_next       = sum_reg;
        if (sum_ready && st_valid_reg)
        begin
            sum_date_next = st_reg.date;
            sum_bad_next  = st_reg.bad;
            sum_next      = dow_sum;
        end

        out_valid_next = out_ready ? sum_valid_reg : out_valid_reg;
        out_date_next  = out_date_reg;
        out_wday_next  = out_wday_reg;
        out_bad_next   = out_bad_reg;
        if (out_ready && sum_valid_reg)
        begin
            out_date_next = sum_date_reg;
            out_bad_next  = sum_bad_reg;
            out_wday_next = sum_bad_reg ? 3'd0 : dow_rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            st_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            st_valid_reg  <= st_valid_next;
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_req_reg   <= in_req_next;
        in_date_reg  <= in_date_next;
        st_reg       <= st_next;
        sum_date_reg <= sum_date_next;
        sum_bad_reg  <= sum_bad_next;
        sum_reg      <= sum_next;
        out_date_reg <= out_date_next;
        out_wday_reg <= out_wday_next;
        out_bad_reg  <= out_bad_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_wday_reg, out_date_reg.day,
                            out_date_reg.month, out_date_reg.year};
    assign m_axis_tuser  = out_bad_reg;

    `ASSERT_IMPLIES(a_bad_wday_zero, clk, rst_n,
        out_valid_reg && out_bad_reg, out_wday_reg == 3'd0)
    `ASSERT_IMPLIES(a_wday_range, clk, rst_n,
        out_valid_reg, out_wday_reg <= 3'd6)
    `ASSERT_IMPLIES(a_ready_when_out_empty, clk, rst_n,
        !out_valid_reg, s_axis_tready)
    `ASSERT_NEXT(a_stalled_out_kept, clk, rst_n,
        out_valid_reg && !m_axis_tready, out_valid_reg)

endmodule

FILE: sv/gdsw_step.sv
module gdsw_step (
    input  logic [1:0]      req_type,
    input  gdsw_pkg::date_t in_date,
    output gdsw_pkg::step_t result
);

    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [26:0] prod;
    logic [7:0]  q100;
    logic [13:0] r100;
    logic        leap;
    logic [3:0]  m_dec;
    logic [4:0]  last_cur;
    logic [4:0]  last_prev;
    logic [13:0] yo;
    logic [3:0]  mo;
    logic [4:0]  dn;
    logic        bad;
    logic        early;

    assign y = in_date.year;
    assign m = in_date.month;
    assign d = in_date.day;

    assign prod = 27'(y) * 27'(gdsw_pkg::DIV100_MUL);
    assign q100 = prod[26:gdsw_pkg::DIV100_SHIFT];
    assign r100 = y - (14'(q100) * 14'd100);
    assign leap = (r100 == 14'd0) ? (q100[1:0] == 2'd0) : (y[1:0] == 2'd0);

    assign m_dec     = m - 4'd1;
    assign last_cur  = gdsw_pkg::month_len(leap, m);
    assign last_prev = gdsw_pkg::month_len(leap, m_dec);

    always_comb
    begin
        yo  = y;
        mo  = m;
        dn  = d;
        bad = (y == 14'd0) || (y > gdsw_pkg::YEAR_MAX);
        case (req_type)
            gdsw_pkg::REQ_NEXT:
            begin
                if (m == 4'd12)
                begin
                    if (d == 5'd31)
                    begin
                        yo  = y + 14'd1;
                        mo  = 4'd1;
                        dn  = 5'd1;
                        bad = (y >= gdsw_pkg::YEAR_MAX);
                    end
                    else
                    begin
                        dn = d + 5'd1;
                    end
                end
                else if (d == last_cur)
                begin
                    mo = m + 4'd1;
                    dn = 5'd1;
                end
                else
                begin
                    dn = d + 5'd1;
                end
            end
            gdsw_pkg::REQ_PREV:
            begin
                if (m == 4'd1)
                begin
                    if (d == 5'd1)
                    begin
                        yo  = y - 14'd1;
                        mo  = 4'd12;
                        dn  = 5'd31;
                        bad = (y <= 14'd1) || (y > gdsw_pkg::YEAR_MAX + 14'd1);
                    end
                    else
                    begin
                        dn = d - 5'd1;
                    end
                end
                else if (d == 5'd1)
                begin
                    mo = m_dec;
                    dn = last_prev;
                end
                else
                begin
                    dn = d - 5'd1;
                end
            end
            default:
            begin
                yo = y;
            end
        endcase
    end

    // january and february count as months 13 and 14 of the year before
    assign early = (mo < 4'd3);

    assign result.date.year  = yo;
    assign result.date.month = mo;
    assign result.date.day   = dn;
    assign result.bad        = bad;
    assign result.zy         = early ? yo - 14'd1 : yo;
    assign result.zm         = early ? mo + 4'd12 : mo;

endmodule

FILE: sv/gdsw_dow_sum.sv
module gdsw_dow_sum (
    input  logic [13:0] zy,
    input  logic [3:0]  zm,
    input  logic [4:0]  day,
    output logic [14:0] sum
);

    logic [26:0] prod;
    logic [7:0]  q100;

    assign prod = 27'(zy) * 27'(gdsw_pkg::DIV100_MUL);
    assign q100 = prod[26:gdsw_pkg::DIV100_SHIFT];

    // y + y/4 - y/100 + y/400 + (13m+8)/5 + d, never negative
    assign sum = 15'(zy) + 15'(zy[13:2]) - 15'(q100) + 15'(q100[7:2])
               + 15'(gdsw_pkg::month_term(zm)) + 15'(day);

endmodule

FILE: sv/gdsw_mod7.sv
module gdsw_mod7 (
    input  logic [14:0] value,
    output logic [2:0]  rem
);

    logic [5:0] fold1;
    logic [3:0] fold2;

    // 8 == 1 mod 7, so octal digits can simply be added
    assign fold1 = 6'(value[2:0]) + 6'(value[5:3]) + 6'(value[8:6])
                 + 6'(value[11:9]) + 6'(value[14:12]);
    assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    assign rem   = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

endmodule
